// File: hdl/ffd_pkg.sv
// shared types and constants of the free-fall flag detector
`timescale 1ns / 1ps
`default_nettype none

package ffd_pkg;

	localparam int TIME_WIDTH_DEFAULT = 32;
	localparam int MID_DEPTH          = 4;
	localparam int OUT_DEPTH          = 8;

	localparam logic [31:0] THRESHOLD_RESET = 32'd150994944;
	localparam logic [15:0] DEBOUNCE_RESET  = 16'd100;
	localparam logic [15:0] HOLD_RESET      = 16'd5000;

	localparam int CFG_INDEX_W = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_DEBOUNCE  = 2'd1,
		REG_HOLD      = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [31:0] threshold_squared;
		logic [15:0] fall_debounce;
		logic [15:0] hold_ms;
	} cfg_regs_t;

	typedef struct packed {
		logic        fall_flag;
		logic        freefall_active;
		logic [31:0] magnitude_squared;
	} result_t;

endpackage

`default_nettype wire

// File: hdl/freefall_flag_detector.sv
// top level of the free-fall flag detector
//
//  channel  handshake            accepted when          carries
//  input    push / full          push && !full          accel_x, accel_y, accel_z, now_ms
//  result   pop / empty          pop && !empty          fall_flag, freefall_active,
//                                                       magnitude_squared
//  config   cfg_valid/cfg_ready  cfg_valid && cfg_ready cfg_index, cfg_data
//
// one word per cycle sustained while not full; squares are registered ahead of the queues
// the path is squares, then sum and compare, then the state update in the back end
// full rises once eight words are in flight and not yet popped
// reset clears the control state and loads the register defaults; config is always ready
`timescale 1ns / 1ps
`default_nettype none

module freefall_flag_detector
	import ffd_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic signed [15:0]     accel_x,
	input  wire logic signed [15:0]     accel_y,
	input  wire logic signed [15:0]     accel_z,
	input  wire logic [31:0]            now_ms,
	input  wire logic                   pop,
	output logic                        empty,
	output logic                        fall_flag,
	output logic                        freefall_active,
	output logic [31:0]                 magnitude_squared,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [31:0]            cfg_data
);

	localparam int MID_W  = TIME_WIDTH + 33;
	localparam int CRED_W = $clog2(OUT_DEPTH + 1);

	cfg_regs_t              cfg_q;
	logic [CRED_W-1:0]      credit_q;
	logic                   in_take;
	logic                   out_take;
	logic [TIME_WIDTH+31:0] now_wide;
	logic [TIME_WIDTH-1:0]  now_t;

	logic                   mid_wr;
	logic [MID_W-1:0]       mid_wdata;
	logic                   mid_full;
	logic                   mid_rd;
	logic [MID_W-1:0]       mid_rdata;
	logic                   mid_empty;

	logic                   out_wr;
	result_t                out_wdata;
	logic                   out_full;
	logic [$bits(result_t)-1:0] out_rdata;
	result_t                res;

	assign cfg_ready = 1'b1;
	assign in_take   = push && !full;
	assign out_take  = pop && !empty;
	assign full      = (credit_q == CRED_W'(OUT_DEPTH));

	// timestamps kept modulo 2^TIME_WIDTH
	assign now_wide = {{TIME_WIDTH{1'b0}}, now_ms};
	assign now_t    = now_wide[TIME_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_squared <= THRESHOLD_RESET;
			cfg_q.fall_debounce     <= DEBOUNCE_RESET;
			cfg_q.hold_ms           <= HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold_squared <= cfg_data;
				REG_DEBOUNCE:  cfg_q.fall_debounce     <= cfg_data[15:0];
				REG_HOLD:      cfg_q.hold_ms           <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// words in flight, bounded by the result queue depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (in_take && !out_take) begin
			credit_q <= credit_q + 1'b1;
		end else if (out_take && !in_take) begin
			credit_q <= credit_q - 1'b1;
		end
	end

	ffd_front #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_take),
		.accel_x (accel_x),
		.accel_y (accel_y),
		.accel_z (accel_z),
		.now_t   (now_t),
		.cfg     (cfg_q),
		.mid_wr  (mid_wr),
		.mid_data(mid_wdata)
	);

	ffd_fifo #(
		.WIDTH(MID_W),
		.DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (mid_wr),
		.wr_data(mid_wdata),
		.full   (mid_full),
		.rd_en  (mid_rd),
		.rd_data(mid_rdata),
		.empty  (mid_empty)
	);

	ffd_back #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mid_empty(mid_empty),
		.mid_data (mid_rdata),
		.mid_rd   (mid_rd),
		.cfg      (cfg_q),
		.out_full (out_full || mid_full && 1'b0),
		.out_wr   (out_wr),
		.out_data (out_wdata)
	);

	ffd_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (out_wr),
		.wr_data(out_wdata),
		.full   (out_full),
		.rd_en  (out_take),
		.rd_data(out_rdata),
		.empty  (empty)
	);

	assign res               = result_t'(out_rdata);
	assign fall_flag         = res.fall_flag;
	assign freefall_active   = res.freefall_active;
	assign magnitude_squared = res.magnitude_squared;

endmodule

`default_nettype wire

// File: hdl/ffd_fifo.sv
// small first-in first-out word queue
`timescale 1ns / 1ps
`default_nettype none

module ffd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             wr_do;
	logic             rd_do;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign wr_do   = wr_en && !full;
	assign rd_do   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_do) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_do) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_do) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_do && !rd_do) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_do && !wr_do) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/ffd_front.sv
// front end: squares the axes, sums them and classifies against the threshold
`timescale 1ns / 1ps
`default_nettype none

module ffd_front
	import ffd_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic signed [15:0]     accel_x,
	input  wire logic signed [15:0]     accel_y,
	input  wire logic signed [15:0]     accel_z,
	input  wire logic [TIME_WIDTH-1:0]  now_t,
	input  wire cfg_regs_t              cfg,
	output logic                        mid_wr,
	output logic [TIME_WIDTH+32:0]      mid_data
);

	logic signed [31:0]    prod_x;
	logic signed [31:0]    prod_y;
	logic signed [31:0]    prod_z;
	logic                  valid_s1;
	logic [30:0]           sq_x_s1;
	logic [30:0]           sq_y_s1;
	logic [30:0]           sq_z_s1;
	logic [TIME_WIDTH-1:0] now_s1;
	logic [31:0]           mag;
	logic                  below;

	assign prod_x = accel_x * accel_x;
	assign prod_y = accel_y * accel_y;
	assign prod_z = accel_z * accel_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			sq_x_s1 <= prod_x[30:0];
			sq_y_s1 <= prod_y[30:0];
			sq_z_s1 <= prod_z[30:0];
			now_s1  <= now_t;
		end
	end

	// sum stays below 2^32 for any three 16-bit axes
	assign mag   = {1'b0, sq_x_s1} + {1'b0, sq_y_s1} + {1'b0, sq_z_s1};
	assign below = (mag < cfg.threshold_squared);

	assign mid_wr   = valid_s1;
	assign mid_data = {now_s1, below, mag};

endmodule

`default_nettype wire

// File: hdl/ffd_back.sv
// back end: free-fall mark, debounce and flag hold state
`timescale 1ns / 1ps
`default_nettype none

module ffd_back
	import ffd_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   mid_empty,
	input  wire logic [TIME_WIDTH+32:0] mid_data,
	output logic                        mid_rd,
	input  wire cfg_regs_t              cfg,
	input  wire logic                   out_full,
	output logic                        out_wr,
	output result_t                     out_data
);

	logic [31:0]            mag;
	logic                   below;
	logic [TIME_WIDTH-1:0]  now_t;
	logic [TIME_WIDTH+15:0] deb_wide;
	logic [TIME_WIDTH+15:0] hold_wide;
	logic [TIME_WIDTH-1:0]  deb_t;
	logic [TIME_WIDTH-1:0]  hold_t;

	logic                   in_freefall_q;
	logic [TIME_WIDTH-1:0]  start_time_q;
	logic                   flag_raised_q;
	logic [TIME_WIDTH-1:0]  raise_time_q;

	logic                   in_freefall_d;
	logic [TIME_WIDTH-1:0]  start_time_d;
	logic                   raised_mid;
	logic                   flag_raised_d;
	logic [TIME_WIDTH-1:0]  raise_time_d;
	logic [TIME_WIDTH-1:0]  since_start;
	logic [TIME_WIDTH-1:0]  since_raise;
	logic                   step;

	assign mag   = mid_data[31:0];
	assign below = mid_data[32];
	assign now_t = mid_data[TIME_WIDTH+32:33];

	assign deb_wide  = {{TIME_WIDTH{1'b0}}, cfg.fall_debounce};
	assign hold_wide = {{TIME_WIDTH{1'b0}}, cfg.hold_ms};
	assign deb_t     = deb_wide[TIME_WIDTH-1:0];
	assign hold_t    = hold_wide[TIME_WIDTH-1:0];

	assign step   = !mid_empty && !out_full;
	assign mid_rd = step;
	assign out_wr = step;

	assign since_start = now_t - start_time_q;

	always_comb begin
		in_freefall_d = in_freefall_q;
		start_time_d  = start_time_q;
		raised_mid    = flag_raised_q;
		raise_time_d  = raise_time_q;
		if (below) begin
			if (!in_freefall_q) begin
				in_freefall_d = 1'b1;
				start_time_d  = now_t;
			end else if ((since_start >= deb_t) && !flag_raised_q) begin
				raised_mid   = 1'b1;
				raise_time_d = now_t;
			end
		end else begin
			in_freefall_d = 1'b0;
		end
	end

	assign since_raise   = now_t - raise_time_d;
	assign flag_raised_d = raised_mid && !(since_raise >= hold_t);

	always_comb begin
		out_data.fall_flag         = flag_raised_d;
		out_data.freefall_active   = in_freefall_d;
		out_data.magnitude_squared = mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_freefall_q <= 1'b0;
			start_time_q  <= '0;
			flag_raised_q <= 1'b0;
			raise_time_q  <= '0;
		end else if (step) begin
			in_freefall_q <= in_freefall_d;
			start_time_q  <= start_time_d;
			flag_raised_q <= flag_raised_d;
			raise_time_q  <= raise_time_d;
		end
	end

endmodule

`default_nettype wire

// File: hdl/ffd_checker.sv
// port-level checks of the free-fall flag detector, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ffd_checker
	import ffd_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   push,
	input wire logic                   full,
	input wire logic                   pop,
	input wire logic                   empty,
	input wire logic                   fall_flag,
	input wire logic                   freefall_active,
	input wire logic [31:0]            magnitude_squared,
	input wire logic                   cfg_ready
);

	// a waiting result holds until popped
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(magnitude_squared)
			&& $stable(fall_flag) && $stable(freefall_active)))
		else $error("waiting result changed before pop");

	// a pop always frees room for another word
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty) |=> !full)
		else $error("full after a pop");

	// full only rises after a word has been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without a taken word");

	// three squared 16-bit axes never exceed 3 * 2^30
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (magnitude_squared <= 32'd3221225472))
		else $error("magnitude out of range");

	// the register port never back-pressures
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind freefall_flag_detector ffd_checker u_ffd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.push             (push),
	.full             (full),
	.pop              (pop),
	.empty            (empty),
	.fall_flag        (fall_flag),
	.freefall_active  (freefall_active),
	.magnitude_squared(magnitude_squared),
	.cfg_ready        (cfg_ready)
);

`default_nettype wire

// File: tb/sv/tb_freefall_flag_detector.sv
// self-checking testbench of the free-fall flag detector: directed corners, then random sample runs
`timescale 1ns / 1ps
`default_nettype none

module tb_freefall_flag_detector;
	import ffd_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam int RANDOM_SAMPLES = 1600;
	localparam int PHASE_SAMPLES  = 160;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int SETTLE_CYCLES  = 40;

	typedef enum logic [1:0] {POP_ALWAYS, POP_MOSTLY, POP_RARELY, POP_BURSTY} pop_mode_t;
	typedef enum logic [2:0] {
		PH_DEFAULT_THR, PH_RANDOM_THR, PH_EXTREME, PH_ZERO_TIMES, PH_WIDE
	} phase_kind_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   push = 1'b0;
	logic                   full;
	logic signed [15:0]     accel_x = '0;
	logic signed [15:0]     accel_y = '0;
	logic signed [15:0]     accel_z = '0;
	logic [31:0]            now_ms = '0;
	logic                   pop = 1'b0;
	logic                   empty;
	logic                   fall_flag;
	logic                   freefall_active;
	logic [31:0]            magnitude_squared;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_THRESHOLD;
	logic [31:0]            cfg_data = '0;

	// detector state as the bench sees it
	logic [31:0] thr_sq;
	logic [15:0] debounce_len;
	logic [15:0] hold_len;
	logic        falling;
	logic [31:0] fall_start;
	logic        flag_up;
	logic [31:0] flag_start;

	result_t     pending_words[$];
	int          err_count = 0;
	int          samples_sent = 0;
	int          words_checked = 0;
	int          reg_writes = 0;
	int          flagged_words = 0;
	int          marked_words = 0;
	int          cycle_count = 0;
	int          burst_left = 0;
	logic [31:0] t_now = '0;

	freefall_flag_detector u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.accel_x          (accel_x),
		.accel_y          (accel_y),
		.accel_z          (accel_z),
		.now_ms           (now_ms),
		.pop              (pop),
		.empty            (empty),
		.fall_flag        (fall_flag),
		.freefall_active  (freefall_active),
		.magnitude_squared(magnitude_squared),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("freefall_flag_detector test failed");
			$finish;
		end
	end

	function automatic result_t fall_state_step(input logic signed [15:0] ax,
			input logic signed [15:0] ay, input logic signed [15:0] az, input logic [31:0] t);
		int          sx;
		int          sy;
		int          sz;
		logic [31:0] mag;
		result_t     word;
		sx = ax;
		sy = ay;
		sz = az;
		mag = sx * sx + sy * sy + sz * sz;
		if (mag < thr_sq) begin
			if (!falling) begin
				falling = 1'b1;
				fall_start = t;
			end else if (32'(t - fall_start) >= 32'(debounce_len) && !flag_up) begin
				flag_up = 1'b1;
				flag_start = t;
			end
		end else begin
			falling = 1'b0;
		end
		if (flag_up && 32'(t - flag_start) >= 32'(hold_len))
			flag_up = 1'b0;
		word.fall_flag = flag_up;
		word.freefall_active = falling;
		word.magnitude_squared = mag;
		return word;
	endfunction

	function automatic int jitter(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
			input logic signed [15:0] az, input logic [31:0] t);
		result_t word;
		@(negedge clk);
		push = 1'b1;
		accel_x = ax;
		accel_y = ay;
		accel_z = az;
		now_ms = t;
		@(posedge clk);
		while (full)
			@(posedge clk);
		word = fall_state_step(ax, ay, az, t);
		pending_words.push_back(word);
		samples_sent++;
		if (word.fall_flag)
			flagged_words++;
		if (word.freefall_active)
			marked_words++;
	endtask

	// bursts of back-to-back words with random gaps between them
	task automatic send_paced(input logic signed [15:0] ax, input logic signed [15:0] ay,
			input logic signed [15:0] az, input logic [31:0] t);
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			push = 1'b0;
			repeat (gap - 1)
				@(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
		send_sample(ax, ay, az, t);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		push = 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_THRESHOLD: thr_sq = data;
			REG_DEBOUNCE: debounce_len = data[15:0];
			REG_HOLD: hold_len = data[15:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_default_registers();
		send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd0);
		send_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'd1);
		// magnitude equal to the threshold is not free fall
		send_sample(16'sd12288, 16'sd0, 16'sd0, 32'd2);
		send_sample(16'sd12287, 16'sd0, 16'sd0, 32'd1000);
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd1050);
		// debounce met exactly
		send_sample(16'sd0, 16'sd0, -16'sd12287, 32'd1100);
		send_sample(16'sd100, -16'sd100, 16'sd50, 32'd3000);
		// hold met exactly, then raised again while still falling
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd6100);
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd6101);
		send_sample(16'sd16384, 16'sd0, 16'sd0, 32'd6200);
		send_sample(16'sd16384, 16'sd0, 16'sd0, 32'd20000);
		// timestamp wraps across the debounce
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'hFFFF_FFF0);
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'h0000_0060);
		send_sample(16'sd0, 16'sd16384, 16'sd0, 32'd70000);
		// time running backwards
		send_sample(-16'sd1, -16'sd1, -16'sd1, 32'd500);
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd400);
	endtask

	task automatic test_zero_hold();
		wait_drained();
		write_register(REG_THRESHOLD, 32'hFFFF_FFFF);
		write_register(REG_DEBOUNCE, 32'd0);
		write_register(REG_HOLD, 32'd0);
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd10);
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd10);
		send_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'd11);
		send_sample(16'sd1, 16'sd2, 16'sd3, 32'd20);
	endtask

	task automatic test_zero_threshold();
		wait_drained();
		write_register(REG_THRESHOLD, 32'd0);
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd30);
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd5000);
	endtask

	task automatic test_register_masking();
		wait_drained();
		write_register(REG_DEBOUNCE, 32'hFFFF_0003);
		write_register(REG_HOLD, 32'hABCD_0008);
		write_register(REG_THRESHOLD, 32'd3221225472);
		// write beyond the register list must leave the threshold alone
		write_register(REG_UNUSED, 32'd0);
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd100);
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd103);
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd110);
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd111);
	endtask

	task automatic test_random_samples();
		int          phase;
		int          phase_end;
		int          step_max;
		int          quiet_len;
		int          loud_len;
		phase_kind_t kind;
		phase = 0;
		while (samples_sent < RANDOM_SAMPLES) begin
			wait_drained();
			kind = phase_kind_t'(phase % 5);
			case (kind)
				PH_DEFAULT_THR: begin
					write_register(REG_THRESHOLD, THRESHOLD_RESET);
					write_register(REG_DEBOUNCE, $urandom_range(0, 300));
					write_register(REG_HOLD, $urandom_range(0, 1500));
				end
				PH_RANDOM_THR: begin
					write_register(REG_THRESHOLD, $urandom_range(20000000, 300000000));
					write_register(REG_DEBOUNCE, $urandom_range(0, 2000));
					write_register(REG_HOLD, $urandom_range(0, 8000));
				end
				PH_EXTREME: begin
					write_register(REG_THRESHOLD, 32'd3221225472);
					write_register(REG_DEBOUNCE, 32'd65535);
					write_register(REG_HOLD, 32'd65535);
				end
				PH_ZERO_TIMES: begin
					write_register(REG_THRESHOLD, $urandom_range(50000000, 250000000));
					write_register(REG_DEBOUNCE, 32'd0);
					write_register(REG_HOLD, 32'd0);
				end
				default: begin
					write_register(REG_THRESHOLD, $urandom);
					write_register(REG_DEBOUNCE, $urandom);
					write_register(REG_HOLD, $urandom);
				end
			endcase
			step_max = (int'(debounce_len) + int'(hold_len)) / 6 + 20;
			t_now = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200000)
				: $urandom;
			phase_end = samples_sent + PHASE_SAMPLES;
			while (samples_sent < phase_end) begin
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 5))
						send_paced(16'($urandom), 16'($urandom), 16'($urandom), $urandom);
				end else begin
					quiet_len = $urandom_range(1, 25);
					loud_len = $urandom_range(0, 5);
					repeat (quiet_len) begin
						t_now = ($urandom_range(0, 24) == 0) ? $urandom
							: t_now + $urandom_range(0, step_max);
						send_paced(16'(jitter(4000)), 16'(jitter(4000)), 16'(jitter(4000)), t_now);
					end
					repeat (loud_len) begin
						t_now = t_now + $urandom_range(0, step_max);
						send_paced(16'(jitter(2000)), 16'(jitter(2000)),
							16'(16384 + jitter(3000)), t_now);
					end
				end
			end
			phase++;
		end
	endtask

	// result side: sample at the rising edge, compare and drive pop at the falling edge
	initial begin : word_checker
		logic      took;
		result_t   seen;
		result_t   want;
		pop_mode_t mode;
		int        mode_left;
		int        stall_left;
		mode = POP_ALWAYS;
		mode_left = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			took = pop && !empty;
			seen.fall_flag = fall_flag;
			seen.freefall_active = freefall_active;
			seen.magnitude_squared = magnitude_squared;
			@(negedge clk);
			if (took) begin
				if (pending_words.size() == 0) begin
					$error("word with none expected: fall_flag %0d freefall_active %0d magnitude %0d",
						seen.fall_flag, seen.freefall_active, seen.magnitude_squared);
					err_count++;
				end else begin
					want = pending_words.pop_front();
					words_checked++;
					if (seen.fall_flag !== want.fall_flag) begin
						$error("fall_flag: expected %0d, got %0d", want.fall_flag, seen.fall_flag);
						err_count++;
					end
					if (seen.freefall_active !== want.freefall_active) begin
						$error("freefall_active: expected %0d, got %0d",
							want.freefall_active, seen.freefall_active);
						err_count++;
					end
					if (seen.magnitude_squared !== want.magnitude_squared) begin
						$error("magnitude_squared: expected %0d, got %0d",
							want.magnitude_squared, seen.magnitude_squared);
						err_count++;
					end
				end
			end
			if (mode_left == 0) begin
				mode = pop_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 300);
			end else begin
				mode_left--;
			end
			case (mode)
				POP_ALWAYS: pop = 1'b1;
				POP_MOSTLY: pop = ($urandom_range(0, 3) != 0);
				POP_RARELY: pop = ($urandom_range(0, 3) == 0);
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						pop = 1'b0;
					end else if ($urandom_range(0, 7) == 0) begin
						stall_left = $urandom_range(4, 20);
						pop = 1'b0;
					end else begin
						pop = 1'b1;
					end
				end
			endcase
		end
	end

	initial begin
		thr_sq = THRESHOLD_RESET;
		debounce_len = DEBOUNCE_RESET;
		hold_len = HOLD_RESET;
		falling = 1'b0;
		fall_start = '0;
		flag_up = 1'b0;
		flag_start = '0;
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_default_registers();
		test_zero_hold();
		test_zero_threshold();
		test_register_masking();
		test_random_samples();
		wait_drained();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		$display("run covered %0d samples and %0d result words across %0d register writes",
			samples_sent, words_checked, reg_writes);
		$display("fall flag raised in %0d words, free-fall mark held in %0d words",
			flagged_words, marked_words);
		if (err_count == 0) begin
			$display("freefall_flag_detector test passed");
		end else begin
			$display("freefall_flag_detector test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
